// ----- src/grid_max_path_dp_assert.svh -----
// Assertion macros used by the grid path controller.
`ifndef GRID_MAX_PATH_DP_ASSERT_SVH
`define GRID_MAX_PATH_DP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/gmp_pkg.sv -----
// Shared types and constants for the grid path block.
package gmp_pkg;

  localparam int DIM_W     = 6;
  localparam int IDX_W     = 10;
  localparam int WIN_W     = 16;
  localparam int TOTAL_W   = 32;
  localparam int AREA_W    = 2 * DIM_W;
  localparam int CFG_IDX_W = 1;
  localparam int STEP_W    = $clog2(DIM_W);

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_READ,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic valid;
    logic has_right;
    logic has_down;
    logic fwd;
  } scan_stage_t;

endpackage

// ----- src/gmp_ram.sv -----
// Simple dual-port RAM with registered read data.
module gmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/gmp_scan_alu.sv -----
// Per-cell best-path update: saturating sums of both moves and their maximum.
module gmp_scan_alu #(
  parameter int WB = 16
) (
  input  logic                        clk,
  input  gmp_pkg::scan_stage_t        stg,
  input  logic [2*WB+1:0]             edge_rdata,
  input  logic [gmp_pkg::TOTAL_W-1:0] best_rdata,
  output logic [gmp_pkg::TOTAL_W-1:0] best_val,
  output logic [gmp_pkg::TOTAL_W-1:0] prev
);
  import gmp_pkg::*;

  logic [TOTAL_W-1:0] prev_r;
  logic [TOTAL_W-1:0] right_w;
  logic [TOTAL_W-1:0] down_w;
  logic [TOTAL_W-1:0] down_src;
  logic [TOTAL_W-1:0] right_sum;
  logic [TOTAL_W-1:0] down_sum;

  function automatic logic [TOTAL_W-1:0] sat_add(logic [TOTAL_W-1:0] a,
                                                 logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

  always_comb begin
    right_w   = edge_rdata[WB] ? TOTAL_W'(edge_rdata[WB-1:0]) : '0;
    down_w    = edge_rdata[2*WB+1] ? TOTAL_W'(edge_rdata[2*WB:WB+1]) : '0;
    down_src  = stg.fwd ? prev_r : best_rdata;
    right_sum = sat_add(prev_r, right_w);
    down_sum  = sat_add(down_src, down_w);
    best_val  = '0;
    if (stg.has_right) begin
      best_val = right_sum;
    end
    if (stg.has_down && (down_sum > best_val)) begin
      best_val = down_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (stg.valid) begin
      prev_r <= best_val;
    end
  end

  assign prev = prev_r;

endmodule

// ----- src/gmp_ctrl.sv -----
// Command sequencer: config, table clear sweep, edge load, reverse cell scan, result.
`include "grid_max_path_dp_assert.svh"

module gmp_ctrl #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32,
  parameter int WB       = 16,
  parameter int CELLS    = 1024,
  parameter int CELL_W   = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gmp_pkg::DIM_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [gmp_pkg::IDX_W-1:0]     in_edge_from,
  input  logic [gmp_pkg::IDX_W-1:0]     in_edge_to,
  input  logic [gmp_pkg::WIN_W-1:0]     in_edge_weight,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gmp_pkg::TOTAL_W-1:0]   out_best_total,
  output logic                          edge_we,
  output logic [CELL_W-1:0]             edge_waddr,
  output logic [2*WB+1:0]               edge_wdata,
  output logic [CELL_W-1:0]             edge_raddr,
  input  logic [2*WB+1:0]               edge_rdata,
  output logic                          best_we,
  output logic [CELL_W-1:0]             best_waddr,
  output logic [CELL_W-1:0]             best_raddr,
  output gmp_pkg::scan_stage_t          stg,
  input  logic [gmp_pkg::TOTAL_W-1:0]   alu_prev
);
  import gmp_pkg::*;

  localparam int EW = 2 * WB + 2;
  localparam logic [CELL_W-1:0] CLR_LAST = CELL_W'(CELLS - 1);

  state_t              state_r, state_nxt;
  logic [DIM_W-1:0]    rows_r, cols_r;
  logic [DIM_W-1:0]    rows_c, cols_c;
  logic [AREA_W-1:0]   area;
  logic [CELL_W-1:0]   clr_r;
  logic [IDX_W-1:0]    from_r, to_r;
  logic [WB-1:0]       w_r;
  logic [AREA_W-1:0]   rem_r;
  logic [STEP_W-1:0]   step_r;
  logic [AREA_W-1:0]   dsub;
  logic [AREA_W-1:0]   k_r;
  logic [DIM_W-1:0]    r_r, c_r;
  scan_stage_t         stg_r;
  logic [AREA_W-1:0]   stg_k_r;
  logic                out_valid_r;
  logic [TOTAL_W-1:0]  out_best_total_r;
  logic                in_acc;
  logic                out_load;
  logic [AREA_W-1:0]   from_ext, to_ext;
  logic                in_rng, is_down, is_right;
  logic                wr_hit;
  logic [EW-1:0]       merged;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int maxv);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      res = DIM_W'(maxv);
    end
    return res;
  endfunction

  assign rows_c = clamp_dim(rows_r, MAX_ROWS);
  assign cols_c = clamp_dim(cols_r, MAX_COLS);
  assign area   = AREA_W'(rows_c) * AREA_W'(cols_c);

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;

  // Edge classification, from registered operands and the division remainder.
  assign from_ext = AREA_W'(from_r);
  assign to_ext   = AREA_W'(to_r);
  assign in_rng   = (from_ext < area) && (to_ext < area);
  assign is_down  = (to_ext == from_ext + AREA_W'(cols_c));
  assign is_right = !is_down && (to_ext == from_ext + AREA_W'(1))
                    && (rem_r != AREA_W'(cols_c) - AREA_W'(1));
  assign dsub     = AREA_W'(cols_c) << step_r;

  always_comb begin
    merged = edge_rdata;
    wr_hit = 1'b0;
    if (in_rng && is_down && !edge_rdata[EW-1]) begin
      wr_hit               = 1'b1;
      merged[EW-1]         = 1'b1;
      merged[EW-2:WB+1]    = w_r;
    end else if (in_rng && is_right && !edge_rdata[WB]) begin
      wr_hit               = 1'b1;
      merged[WB]           = 1'b1;
      merged[WB-1:0]       = w_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_command)
            CMD_CLEAR:   state_nxt = ST_CLEAR;
            CMD_LOAD:    state_nxt = ST_DIV;
            CMD_COMPUTE: state_nxt = ST_SCAN;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        if (step_r == '0) state_nxt = ST_READ;
      end
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      ST_SCAN: begin
        if (k_r == '0) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DELIVER;
      ST_DELIVER: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    out_load   = (state_r == ST_DELIVER) && (!out_valid_r || !out_stall);
    edge_we    = 1'b0;
    edge_waddr = CELL_W'(from_r);
    edge_wdata = merged;
    edge_raddr = CELL_W'(from_r);
    best_raddr = CELL_W'(k_r + AREA_W'(cols_c));
    best_we    = stg_r.valid;
    best_waddr = CELL_W'(stg_k_r);
    unique case (state_r)
      ST_CLEAR: begin
        edge_we    = 1'b1;
        edge_waddr = clr_r;
        edge_wdata = '0;
      end
      ST_WRITE: edge_we = wr_hit;
      ST_SCAN:  edge_raddr = CELL_W'(k_r);
      ST_IDLE, ST_DIV, ST_READ, ST_DRAIN, ST_DELIVER: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      rows_r      <= DIM_W'(1);
      cols_r      <= DIM_W'(1);
      clr_r       <= '0;
      stg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROWS: rows_r <= cfg_wdata;
          REG_COLS: cols_r <= cfg_wdata;
        endcase
      end
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + CELL_W'(1);
      end else begin
        clr_r <= '0;
      end
      stg_r.valid     <= (state_r == ST_SCAN);
      stg_r.has_right <= (c_r != cols_c - DIM_W'(1));
      stg_r.has_down  <= (r_r != rows_c - DIM_W'(1));
      stg_r.fwd       <= (cols_c == DIM_W'(1));
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    stg_k_r <= k_r;
    if (out_load) begin
      out_best_total_r <= alu_prev;
    end
    if (in_acc) begin
      from_r <= in_edge_from;
      to_r   <= in_edge_to;
      w_r    <= WB'({{WB{1'b0}}, in_edge_weight});
      rem_r  <= AREA_W'(in_edge_from);
      step_r <= STEP_W'(DIM_W - 1);
      k_r    <= area - AREA_W'(1);
      r_r    <= rows_c - DIM_W'(1);
      c_r    <= cols_c - DIM_W'(1);
    end else if (state_r == ST_DIV) begin
      if (rem_r >= dsub) begin
        rem_r <= rem_r - dsub;
      end
      step_r <= step_r - STEP_W'(1);
    end else if (state_r == ST_SCAN) begin
      k_r <= k_r - AREA_W'(1);
      if (c_r == '0) begin
        c_r <= cols_c - DIM_W'(1);
        r_r <= r_r - DIM_W'(1);
      end else begin
        c_r <= c_r - DIM_W'(1);
      end
    end
  end

  assign stg            = stg_r;
  assign out_valid      = out_valid_r;
  assign out_best_total = out_best_total_r;

  `GMP_ASSERT_IMP(a_stage_in_scan, stg_r.valid,
    (state_r == ST_SCAN) || (state_r == ST_DRAIN), "scan stage live outside scan")
  `GMP_ASSERT_IMP(a_scan_in_grid, state_r == ST_SCAN,
    (r_r < rows_c) && (c_r < cols_c), "scan position left the grid")
  `GMP_ASSERT_IMP(a_best_wr_in_grid, best_we, stg_k_r < area,
    "best write beyond grid")
  `GMP_ASSERT_IMP(a_result_after_deliver, $rose(out_valid_r),
    $past(state_r) == ST_DELIVER, "result raised outside deliver")
  `GMP_ASSERT_NXT(a_clear_ends_idle, (state_r == ST_CLEAR) && (clr_r == CLR_LAST),
    state_r == ST_IDLE, "clear sweep did not end in idle")

endmodule

// ----- src/grid_max_path_dp.sv -----
// Top level of the best right/down grid path engine.
// Clear zeroes one edge-table entry per cycle across all MAX_ROWS*MAX_COLS entries,
// and the same sweep runs after reset while in_stall is high.
// Load edge runs a 6-step remainder unit that classifies the edge, then one
// read-modify-write of the edge table. Compute scans one cell per cycle, set by
// the single read port of the best-path memory, walking from the last cell back
// to the first; the result then sits in an output register, so the next item may
// be accepted while it waits to be taken.
module grid_max_path_dp #(
  parameter int MAX_ROWS    = 32,
  parameter int MAX_COLS    = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gmp_pkg::DIM_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [gmp_pkg::IDX_W-1:0]     in_edge_from,
  input  logic [gmp_pkg::IDX_W-1:0]     in_edge_to,
  input  logic [gmp_pkg::WIN_W-1:0]     in_edge_weight,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gmp_pkg::TOTAL_W-1:0]   out_best_total
);
  import gmp_pkg::*;

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int EW     = 2 * WEIGHT_BITS + 2;

  logic               edge_we;
  logic [CELL_W-1:0]  edge_waddr, edge_raddr;
  logic [EW-1:0]      edge_wdata, edge_rdata;
  logic               best_we;
  logic [CELL_W-1:0]  best_waddr, best_raddr;
  logic [TOTAL_W-1:0] best_wdata, best_rdata;
  logic [TOTAL_W-1:0] alu_prev;
  scan_stage_t        stg;

  gmp_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .WB       (WEIGHT_BITS),
    .CELLS    (CELLS),
    .CELL_W   (CELL_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_edge_from   (in_edge_from),
    .in_edge_to     (in_edge_to),
    .in_edge_weight (in_edge_weight),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_best_total (out_best_total),
    .edge_we        (edge_we),
    .edge_waddr     (edge_waddr),
    .edge_wdata     (edge_wdata),
    .edge_raddr     (edge_raddr),
    .edge_rdata     (edge_rdata),
    .best_we        (best_we),
    .best_waddr     (best_waddr),
    .best_raddr     (best_raddr),
    .stg            (stg),
    .alu_prev       (alu_prev)
  );

  gmp_ram #(
    .WIDTH (EW),
    .DEPTH (CELLS),
    .AW    (CELL_W)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  gmp_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (CELLS),
    .AW    (CELL_W)
  ) u_best_ram (
    .clk   (clk),
    .we    (best_we),
    .waddr (best_waddr),
    .wdata (best_wdata),
    .raddr (best_raddr),
    .rdata (best_rdata)
  );

  gmp_scan_alu #(
    .WB (WEIGHT_BITS)
  ) u_alu (
    .clk        (clk),
    .stg        (stg),
    .edge_rdata (edge_rdata),
    .best_rdata (best_rdata),
    .best_val   (best_wdata),
    .prev       (alu_prev)
  );

endmodule

// ----- verif/grid_max_path_dp_test.sv -----
// Self-checking testbench for the grid_max_path_dp right/down best path engine.
`timescale 1ns / 100ps

module grid_max_path_dp_test;
  import gmp_pkg::*;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int RANDOM_ITEMS = 580;
  localparam int SETTLE_CYCLES = 1100;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] edge_from;
    logic [IDX_W-1:0] edge_to;
    logic [WIN_W-1:0] edge_weight;
  } grid_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_command = CMD_CLEAR;
  logic [IDX_W-1:0]     in_edge_from = '0;
  logic [IDX_W-1:0]     in_edge_to = '0;
  logic [WIN_W-1:0]     in_edge_weight = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TOTAL_W-1:0]   out_best_total;

  grid_item_t         pending_items[$];
  logic [TOTAL_W-1:0] expected_totals[$];
  grid_item_t         current_item;

  logic [DIM_W-1:0] rows_reg = 6'd1;
  logic [DIM_W-1:0] cols_reg = 6'd1;
  logic [WIN_W-1:0] right_wt [CELLS];
  logic             right_has [CELLS];
  logic [WIN_W-1:0] down_wt [CELLS];
  logic             down_has [CELLS];
  logic [TOTAL_W-1:0] best_to_end [CELLS];

  int error_count = 0;
  int items_made = 0;
  int send_idle_pct = 36;
  int recv_idle_pct = 55;

  grid_max_path_dp i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_edge_from   (in_edge_from),
    .in_edge_to     (in_edge_to),
    .in_edge_weight (in_edge_weight),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_best_total (out_best_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    return (int'(v) > maxv) ? maxv : int'(v);
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_sum(input logic [TOTAL_W-1:0] a,
                                                 input logic [WIN_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + b;
    return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
  endfunction

  function automatic logic [WIN_W-1:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      default: return WIN_W'($urandom);
    endcase
  endfunction

  task automatic clear_edge_tables();
    for (int i = 0; i < CELLS; i++) begin
      right_wt[i] = '0;
      right_has[i] = 1'b0;
      down_wt[i] = '0;
      down_has[i] = 1'b0;
    end
  endtask

  task automatic apply_grid_item(input grid_item_t it);
    int rows, cols, n, from, to;
    logic [TOTAL_W-1:0] best, down_total;
    rows = eff_dim(rows_reg, MAX_ROWS);
    cols = eff_dim(cols_reg, MAX_COLS);
    n = rows * cols;
    from = int'(it.edge_from);
    to = int'(it.edge_to);
    case (it.cmd)
      CMD_CLEAR: clear_edge_tables();
      CMD_LOAD: begin
        if (from < n && to < n) begin
          if (to == from + cols) begin
            if (!down_has[from]) begin
              down_has[from] = 1'b1;
              down_wt[from] = it.edge_weight;
            end
          end else if (to == from + 1 && (from % cols) != cols - 1) begin
            if (!right_has[from]) begin
              right_has[from] = 1'b1;
              right_wt[from] = it.edge_weight;
            end
          end
        end
      end
      CMD_COMPUTE: begin
        for (int k = n - 1; k >= 0; k--) begin
          best = '0;
          if ((k % cols) != cols - 1)
            best = sat_sum(best_to_end[k + 1], right_has[k] ? right_wt[k] : '0);
          if ((k / cols) != rows - 1) begin
            down_total = sat_sum(best_to_end[k + cols], down_has[k] ? down_wt[k] : '0);
            if (down_total > best) best = down_total;
          end
          best_to_end[k] = best;
        end
        expected_totals.push_back(best_to_end[0]);
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [1:0] cmd, input int from, input int to,
                           input logic [WIN_W-1:0] weight);
    grid_item_t it;
    it.cmd = cmd;
    it.edge_from = IDX_W'(from);
    it.edge_to = IDX_W'(to);
    it.edge_weight = weight;
    pending_items.push_back(it);
    if (cmd != CMD_UNUSED) items_made++;
  endtask

  task automatic push_noise(input int rows, input int cols);
    int n, from;
    n = rows * cols;
    case ($urandom_range(0, 9))
      2: push_item(CMD_UNUSED, $urandom, $urandom, WIN_W'($urandom));
      3: begin
        if (cols > 1) begin
          from = $urandom_range(0, rows - 1) * cols + cols - 1;
          push_item(CMD_LOAD, from, from + 1, rand_weight());
        end else begin
          push_item(CMD_LOAD, $urandom, $urandom, rand_weight());
        end
      end
      4, 5: push_item(CMD_LOAD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                      rand_weight());
      6: begin
        from = n - 1 - $urandom_range(0, cols - 1);
        push_item(CMD_LOAD, from, from + cols, rand_weight());
      end
      7: begin
        from = $urandom_range(1, n);
        push_item(CMD_LOAD, from, from - 1, rand_weight());
      end
      8: begin
        if ($urandom_range(0, 3) == 0) push_item(CMD_CLEAR, $urandom, $urandom, '0);
        else push_item(CMD_LOAD, $urandom, $urandom, rand_weight());
      end
      default: push_item(CMD_LOAD, $urandom, $urandom, WIN_W'($urandom));
    endcase
  endtask

  task automatic push_neighbor_load(input int rows, input int cols);
    int from;
    if (rows == 1 && cols == 1) begin
      push_noise(rows, cols);
    end else if (cols == 1 || (rows > 1 && $urandom_range(0, 1) == 1)) begin
      from = $urandom_range(0, rows - 2) * cols + $urandom_range(0, cols - 1);
      push_item(CMD_LOAD, from, from + cols, rand_weight());
    end else begin
      from = $urandom_range(0, rows - 1) * cols + $urandom_range(0, cols - 2);
      push_item(CMD_LOAD, from, from + 1, rand_weight());
    end
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_totals.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ROWS) rows_reg = val;
    else cols_reg = val;
  endtask

  task automatic run_phase(input logic [DIM_W-1:0] rows_val, input logic [DIM_W-1:0] cols_val);
    int rows, cols, loads;
    wait_quiet();
    write_reg(REG_ROWS, rows_val);
    write_reg(REG_COLS, cols_val);
    @(negedge clk);
    if (items_made < 200 + 25) begin
      send_idle_pct = 36;
      recv_idle_pct = 55;
    end else if (items_made < 400 + 25) begin
      send_idle_pct = 55;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    rows = eff_dim(rows_val, MAX_ROWS);
    cols = eff_dim(cols_val, MAX_COLS);
    if ($urandom_range(0, 1) == 1) push_item(CMD_CLEAR, $urandom, $urandom, WIN_W'($urandom));
    loads = $urandom_range(24, 48);
    for (int i = 0; i < loads; i++) begin
      if (i % 8 == 7) push_item(CMD_COMPUTE, $urandom, $urandom, WIN_W'($urandom));
      else if ($urandom_range(0, 3) != 0) push_neighbor_load(rows, cols);
      else push_noise(rows, cols);
    end
    push_item(CMD_COMPUTE, $urandom, $urandom, WIN_W'($urandom));
  endtask

  always @(posedge clk) begin : drive_items
    logic channel_free;
    if (rst_n) begin
      channel_free = !in_valid || !in_stall;
      if (in_valid && !in_stall) apply_grid_item(current_item);
      if (channel_free) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          current_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_command <= current_item.cmd;
          in_edge_from <= current_item.edge_from;
          in_edge_to <= current_item.edge_to;
          in_edge_weight <= current_item.edge_weight;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_totals
    logic [TOTAL_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_totals.size() == 0) begin
        $error("best_total: expected none, actual %0d", out_best_total);
        error_count++;
      end else begin
        want = expected_totals.pop_front();
        if (out_best_total !== want) begin
          $error("best_total: expected %0d, actual %0d", want, out_best_total);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [DIM_W-1:0] r, c;
    int phase_idx;
    clear_edge_tables();
    for (int i = 0; i < CELLS; i++) best_to_end[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_item(CMD_LOAD, 0, 1, 16'hFFFF);
    push_item(CMD_COMPUTE, 0, 0, '0);
    wait_quiet();
    write_reg(REG_ROWS, 6'd3);
    write_reg(REG_COLS, 6'd4);
    @(negedge clk);
    push_item(CMD_LOAD, 0, 1, 16'hFFFF);
    push_item(CMD_LOAD, 0, 1, 16'h0001);
    push_item(CMD_LOAD, 1, 5, 16'h8000);
    push_item(CMD_LOAD, 3, 4, 16'hFFFF);
    push_item(CMD_LOAD, 0, 2, 16'h1234);
    push_item(CMD_LOAD, 11, 12, 16'h7777);
    push_item(CMD_LOAD, 1023, 1023, 16'hFFFF);
    push_item(CMD_UNUSED, 1023, 0, 16'hFFFF);
    push_item(CMD_LOAD, 5, 6, 16'h0000);
    push_item(CMD_LOAD, 6, 7, 16'h00FF);
    push_item(CMD_LOAD, 7, 11, 16'hAAAA);
    push_item(CMD_COMPUTE, 1023, 1023, 16'hFFFF);
    push_item(CMD_CLEAR, 0, 0, '0);
    push_item(CMD_COMPUTE, 0, 0, '0);
    push_item(CMD_LOAD, 8, 9, 16'h5555);
    push_item(CMD_LOAD, 4, 8, 16'h0001);
    push_item(CMD_COMPUTE, 0, 0, '0);
    wait_quiet();
    write_reg(REG_ROWS, 6'd5);
    write_reg(REG_COLS, 6'd1);
    @(negedge clk);
    push_item(CMD_LOAD, 0, 1, 16'hFFFF);
    push_item(CMD_LOAD, 1, 2, 16'h0001);
    push_item(CMD_LOAD, 2, 3, 16'h0002);
    push_item(CMD_COMPUTE, 0, 0, '0);
    items_made = 25;

    phase_idx = 0;
    while (items_made < RANDOM_ITEMS + 25) begin
      case (phase_idx)
        0: begin r = 6'd32; c = 6'd32; end
        1: begin r = 6'd0;  c = 6'd0;  end
        2: begin r = 6'd63; c = 6'd63; end
        3: begin r = 6'd1;  c = 6'd32; end
        4: begin r = 6'd32; c = 6'd1;  end
        5: begin r = 6'd33; c = 6'd5;  end
        6: begin r = 6'd2;  c = 6'd63; end
        default: begin
          if ($urandom_range(0, 4) != 0) begin
            r = DIM_W'($urandom_range(1, 8));
            c = DIM_W'($urandom_range(1, 8));
          end else begin
            r = DIM_W'($urandom_range(0, 63));
            c = DIM_W'($urandom_range(0, 63));
          end
        end
      endcase
      run_phase(r, c);
      phase_idx++;
    end

    wait_quiet();
    if (expected_totals.size() != 0) begin
      $error("best_total: %0d expected results never arrived", expected_totals.size());
      error_count++;
    end
    if (error_count == 0)
      $display("grid_max_path_dp_test OK");
    else
      $display("grid_max_path_dp_test NOT OK");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("grid_max_path_dp_test NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/gmp_pkg.sv
src/gmp_ram.sv
src/gmp_scan_alu.sv
src/gmp_ctrl.sv
src/grid_max_path_dp.sv
verif/grid_max_path_dp_test.sv
